// ===== src/ksa_pkg.sv =====
// Shared constants, types and helpers for the shared-store stack block.
package ksa_pkg;

  localparam int ENTRIES    = 16;
  localparam int STACKS     = 4;
  localparam int DATA_WIDTH = 32;

  localparam int VALUE_W = 32;
  localparam int SEL_W   = 2;
  localparam int PTR_W   = $clog2(ENTRIES + 1);
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SIDX_W  = (STACKS > 1) ? $clog2(STACKS) : 1;

  localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(ENTRIES);

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  typedef struct packed {
    logic capture;
    logic read;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

  function automatic logic [PTR_W-1:0] clean_ptr(input logic [PTR_W-1:0] p);
    clean_ptr = (p < NULL_PTR) ? p : NULL_PTR;
  endfunction

endpackage

// ===== src/ksa_ctrl.sv =====
// Controller state machine: sequences capture, memory read and commit.
module ksa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ksa_pkg::stat_t stat_i,
  output ksa_pkg::cmd_t  cmd_o
);
  import ksa_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == ST_IDLE) || ((state_q == ST_WRITE) && stat_i.out_free);
  assign accept     = in_valid_i && in_ready_o;

  assign cmd_o.capture = accept;
  assign cmd_o.read    = (state_q == ST_READ);
  assign cmd_o.commit  = (state_q == ST_WRITE) && stat_i.out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_READ;
      end
      ST_READ: begin
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        if (stat_i.out_free) state_d = accept ? ST_READ : ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/ksa_datapath.sv =====
// Datapath: stack heads, free-list head, link and data stores, result register.
module ksa_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  ksa_pkg::cmd_t                         cmd_i,
  output ksa_pkg::stat_t                        stat_o,
  input  logic                                  mode_i,
  input  logic [ksa_pkg::SEL_W-1:0]             stack_sel_i,
  input  logic signed [ksa_pkg::VALUE_W-1:0]    push_value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [ksa_pkg::VALUE_W-1:0]    pop_value_o,
  output logic [1:0]                            status_o,
  output logic                                  all_full_o,
  output logic                                  sel_empty_o
);
  import ksa_pkg::*;

  logic                         mode_q;
  logic [SEL_W-1:0]             sel_q;
  logic signed [VALUE_W-1:0]    value_q;

  logic [PTR_W-1:0]             head_q [STACKS];
  logic [PTR_W-1:0]             free_q;
  logic [PTR_W-1:0]             link_q [ENTRIES];
  logic signed [DATA_WIDTH-1:0] data_mem [ENTRIES];

  logic [PTR_W-1:0]             link_rd_q;
  logic signed [DATA_WIDTH-1:0] data_rd_q;

  logic                         out_valid_q;
  logic signed [VALUE_W-1:0]    pop_value_q;
  logic [1:0]                   status_q;
  logic                         all_full_q;
  logic                         sel_empty_q;

  logic                         valid_sel;
  logic [PTR_W-1:0]             fh;
  logic [PTR_W-1:0]             hd;
  logic [PTR_W-1:0]             next_ptr;
  logic [PTR_W-1:0]             rd_addr;
  logic                         push_ok;
  logic                         pop_ok;
  logic signed [VALUE_W-1:0]    pop_value_d;
  logic [1:0]                   status_d;
  logic                         all_full_d;
  logic                         sel_empty_d;

  assign valid_sel = (int'(sel_q) < STACKS);
  assign fh        = clean_ptr(free_q);
  assign hd        = valid_sel ? clean_ptr(head_q[sel_q[SIDX_W-1:0]]) : NULL_PTR;
  assign next_ptr  = clean_ptr(link_rd_q);
  assign rd_addr   = (mode_q == MODE_POP) ? hd : fh;
  assign push_ok   = (mode_q == MODE_PUSH) && valid_sel && (fh != NULL_PTR);
  assign pop_ok    = (mode_q == MODE_POP) && (hd != NULL_PTR);

  always_comb begin
    pop_value_d = '0;
    status_d    = STATUS_OK;
    all_full_d  = (fh == NULL_PTR);
    sel_empty_d = (hd == NULL_PTR);
    if (mode_q == MODE_PUSH) begin
      if (push_ok) begin
        all_full_d  = (next_ptr == NULL_PTR);
        sel_empty_d = 1'b0;
      end else begin
        status_d = STATUS_OVERFLOW;
      end
    end else begin
      if (pop_ok) begin
        pop_value_d = VALUE_W'(data_rd_q);
        all_full_d  = 1'b0;
        sel_empty_d = (next_ptr == NULL_PTR);
      end else begin
        status_d    = STATUS_UNDERFLOW;
        pop_value_d = '1;
        sel_empty_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q  <= mode_i;
      sel_q   <= stack_sel_i;
      value_q <= push_value_i;
    end
    if (cmd_i.read) begin
      link_rd_q <= link_q[rd_addr[IDX_W-1:0]];
      data_rd_q <= data_mem[rd_addr[IDX_W-1:0]];
    end
    if (cmd_i.commit && push_ok) begin
      data_mem[fh[IDX_W-1:0]] <= DATA_WIDTH'(value_q);
    end
    if (cmd_i.commit) begin
      pop_value_q <= pop_value_d;
      status_q    <= status_d;
      all_full_q  <= all_full_d;
      sel_empty_q <= sel_empty_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q <= '0;
      for (int s = 0; s < STACKS; s++) begin
        head_q[s] <= NULL_PTR;
      end
      for (int e = 0; e < ENTRIES; e++) begin
        link_q[e] <= PTR_W'(e + 1);
      end
    end else if (cmd_i.commit) begin
      if (push_ok) begin
        free_q                     <= next_ptr;
        link_q[fh[IDX_W-1:0]]      <= hd;
        head_q[sel_q[SIDX_W-1:0]]  <= fh;
      end else if (pop_ok) begin
        head_q[sel_q[SIDX_W-1:0]]  <= next_ptr;
        link_q[hd[IDX_W-1:0]]      <= fh;
        free_q                     <= hd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign pop_value_o = pop_value_q;
  assign status_o    = status_q;
  assign all_full_o  = all_full_q;
  assign sel_empty_o = sel_empty_q;

endmodule

// ===== src/k_stacks_shared_array_unit.sv =====
// Top level: several linked-list stacks sharing one entry store with a free list.
//
// Input channel (in_valid_i/in_ready_o) carries one operation per transaction:
// mode_i (0 push, 1 pop), stack_sel_i and push_value_i. Output channel
// (out_valid_o/out_ready_i) returns one result per operation: pop_value_o,
// status_o (0 ok, 1 overflow, 2 underflow), all_full_o and sel_empty_o.
// Each operation is captured on acceptance, then reads the link and data
// stores at the selected head or free-list head (registered read), then
// writes back the pointers and loads the result register. While it reads,
// the block takes no new operation and holds in_ready_o low.
// A new operation is taken in the same cycle that the previous result is
// loaded, so a result waiting in the output register does not block the next
// input; if the receiver stalls, the block holds in its write-back step until
// the output register frees up.
// Reset empties all stacks and chains every entry onto the free list; the data
// store is not cleared; read data is used only on pops of entries a push wrote.
module k_stacks_shared_array_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                mode_i,
  input  logic [ksa_pkg::SEL_W-1:0]           stack_sel_i,
  input  logic signed [ksa_pkg::VALUE_W-1:0]  push_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [ksa_pkg::VALUE_W-1:0]  pop_value_o,
  output logic [1:0]                          status_o,
  output logic                                all_full_o,
  output logic                                sel_empty_o
);
  import ksa_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  ksa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ksa_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .mode_i       (mode_i),
    .stack_sel_i  (stack_sel_i),
    .push_value_i (push_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pop_value_o  (pop_value_o),
    .status_o     (status_o),
    .all_full_o   (all_full_o),
    .sel_empty_o  (sel_empty_o)
  );

endmodule
